[rtl/bfc_pkg.sv]
// ----------------------------------------------------------------------------
// bfc_pkg
// Shared types, register indexes and the scale table for the barometer
// FIFO compensation block.
// ----------------------------------------------------------------------------
`default_nettype none

package bfc_pkg;

  localparam int unsigned WordW  = 24;
  localparam int unsigned FracW  = 24;
  localparam int unsigned KW     = 23;
  localparam int unsigned QW     = 30;
  localparam int unsigned AccW   = 64;
  localparam int unsigned BMagW  = 58;
  localparam int unsigned BHalfW = 29;

  typedef enum logic [2:0] {
    REG_TEMP_COEFFS  = 3'd0,
    REG_PRES_OFFSET  = 3'd1,
    REG_PRES_LINEAR  = 3'd2,
    REG_TEMP_LINEAR  = 3'd3,
    REG_CROSS_LINEAR = 3'd4,
    REG_PRES_SQUARE  = 3'd5,
    REG_HIGH_ORDER   = 3'd6,
    REG_OVERSAMPLE   = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic signed [11:0] c0;
    logic signed [11:0] c1;
    logic signed [19:0] c00;
    logic signed [19:0] c10;
    logic signed [15:0] c01;
    logic signed [15:0] c11;
    logic signed [15:0] c20;
    logic signed [15:0] c21;
    logic signed [15:0] c30;
    logic [2:0]         p_osr;
    logic [2:0]         t_osr;
  } cfg_t;

  // Classified word: tag, sign and magnitude of the raw value.
  typedef struct packed {
    logic              is_p;
    logic              neg;
    logic [WordW-1:0]  mag;
  } item_t;

  function automatic logic [KW-1:0] scale_k(input logic [2:0] code);
    logic [KW-1:0] k;
    unique case (code)
      3'd0: k = 23'd524288;
      3'd1: k = 23'd1572864;
      3'd2: k = 23'd3670016;
      3'd3: k = 23'd7864320;
      3'd4: k = 23'd253952;
      3'd5: k = 23'd516096;
      3'd6: k = 23'd1040384;
      3'd7: k = 23'd2088960;
      default: k = 23'd524288;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

[rtl/bfc_front.sv]
// ----------------------------------------------------------------------------
// bfc_front
// Accepts FIFO words, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module bfc_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [bfc_pkg::WordW-1:0]   fifo_word_i,
  output logic                             fe_valid_o,
  output bfc_pkg::item_t                   fe_item_o,
  input  wire logic                        fe_pop_i
);

  bfc_pkg::item_t      mem_q [2];
  bfc_pkg::item_t      cls;
  logic                wp_q, wp_d, rp_q, rp_d;
  logic [1:0]          cnt_q, cnt_d;
  logic                push;

  always_comb begin
    cls.is_p = fifo_word_i[0];
    cls.neg  = fifo_word_i[bfc_pkg::WordW-1];
    cls.mag  = cls.neg ? (~fifo_word_i + 24'd1) : fifo_word_i;
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign fe_valid_o = (cnt_q != 2'd0);
  assign fe_item_o  = mem_q[rp_q];

  always_comb begin
    wp_d  = push ? ~wp_q : wp_q;
    rp_d  = fe_pop_i ? ~rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, fe_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= cls;
    end
  end

endmodule

`default_nettype wire

[rtl/bfc_back.sv]
// ----------------------------------------------------------------------------
// bfc_back
// Scales one word by restoring division, then evaluates the temperature
// line directly or the pressure polynomial on a shared two-pass multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module bfc_back (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire bfc_pkg::cfg_t         cfg_i,
  input  wire logic                  fe_valid_i,
  input  wire bfc_pkg::item_t        fe_item_i,
  output logic                       fe_pop_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic signed [31:0]         value_o,
  output logic                       is_pressure_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_TEMP, ST_MLO, ST_MHI, ST_MACC, ST_FINAL
  } state_e;

  localparam int unsigned NumW = bfc_pkg::WordW + bfc_pkg::FracW;
  localparam int unsigned ProdW = bfc_pkg::QW + bfc_pkg::BMagW;

  state_e                          state_q;
  logic                            isp_q, neg_q;
  logic [bfc_pkg::KW-1:0]          k_q;
  logic [bfc_pkg::KW-1:0]          rem_q;
  logic [bfc_pkg::QW-1:0]          nlo_q, q_q;
  logic [4:0]                      cnt_q;
  logic [2:0]                      step_q;
  logic                            lt_neg_q;
  logic [bfc_pkg::QW-1:0]          lt_mag_q;
  logic signed [bfc_pkg::AccW-1:0] acc_q, hsave_q;
  logic [bfc_pkg::QW-1:0]          amag_q;
  logic                            sgn_q;
  logic [bfc_pkg::BHalfW-1:0]      bhi_q;
  logic [bfc_pkg::QW+bfc_pkg::BHalfW-1:0] plo_q, phi_q;
  logic                            out_valid_q, isp_out_q;
  logic signed [31:0]              value_q;

  // Division setup
  logic [2:0]                      kcode;
  logic [bfc_pkg::KW-1:0]          kval;
  logic [NumW-1:0]                 num;
  // Division step
  logic [bfc_pkg::KW:0]            trial, diff;
  logic                            ge;
  // Multiplier operands
  logic signed [bfc_pkg::AccW-1:0] bsel, addend, bneg_v;
  logic [bfc_pkg::BMagW-1:0]       bmag;
  logic [bfc_pkg::QW-1:0]          asel;
  logic                            aneg;
  logic [ProdW-1:0]                prod;
  logic [ProdW-1:0]                prod_r;
  logic signed [bfc_pkg::AccW-1:0] term, acc_step;
  // Temperature line
  logic signed [bfc_pkg::QW:0]     t_s;
  logic signed [bfc_pkg::AccW-1:0] temp_acc;
  // Final rounding
  logic [bfc_pkg::AccW-1:0]        amag;
  logic [48:0]                     rr;
  logic signed [31:0]              sat;
  logic                            out_free;

  always_comb begin
    kcode = fe_item_i.is_p ? cfg_i.p_osr : cfg_i.t_osr;
    kval  = bfc_pkg::scale_k(kcode);
    num   = {fe_item_i.mag, {bfc_pkg::FracW{1'b0}}} + NumW'(kval >> 1);
  end

  always_comb begin
    trial = {rem_q, nlo_q[bfc_pkg::QW-1]};
    ge    = (trial >= {1'b0, k_q});
    diff  = trial - {1'b0, k_q};
  end

  always_comb begin
    unique case (step_q)
      3'd0:    bsel = bfc_pkg::AccW'(cfg_i.c30) <<< bfc_pkg::FracW;
      3'd3:    bsel = bfc_pkg::AccW'(cfg_i.c21) <<< bfc_pkg::FracW;
      default: bsel = acc_q;
    endcase
    unique case (step_q)
      3'd0:    addend = bfc_pkg::AccW'(cfg_i.c20) <<< bfc_pkg::FracW;
      3'd1:    addend = bfc_pkg::AccW'(cfg_i.c10) <<< bfc_pkg::FracW;
      3'd2:    addend = bfc_pkg::AccW'(cfg_i.c00) <<< bfc_pkg::FracW;
      3'd3:    addend = bfc_pkg::AccW'(cfg_i.c11) <<< bfc_pkg::FracW;
      3'd4:    addend = bfc_pkg::AccW'(cfg_i.c01) <<< bfc_pkg::FracW;
      default: addend = hsave_q;
    endcase
    bneg_v = -bsel;
    bmag   = bsel[bfc_pkg::AccW-1] ? bneg_v[bfc_pkg::BMagW-1:0] : bsel[bfc_pkg::BMagW-1:0];
    asel   = (step_q == 3'd5) ? lt_mag_q : q_q;
    aneg   = (step_q == 3'd5) ? lt_neg_q : neg_q;
  end

  always_comb begin
    prod     = {phi_q, {bfc_pkg::BHalfW{1'b0}}} + ProdW'(plo_q);
    prod_r   = prod + ProdW'(1 << (bfc_pkg::FracW - 1));
    term     = sgn_q ? -$signed(prod_r[bfc_pkg::FracW +: bfc_pkg::AccW])
                     :  $signed(prod_r[bfc_pkg::FracW +: bfc_pkg::AccW]);
    acc_step = addend + term;
  end

  always_comb begin
    t_s      = neg_q ? -$signed({1'b0, q_q}) : $signed({1'b0, q_q});
    temp_acc = (bfc_pkg::AccW'(cfg_i.c0) <<< (bfc_pkg::FracW - 1))
             + bfc_pkg::AccW'(cfg_i.c1) * bfc_pkg::AccW'(t_s);
  end

  // Round Q.24 to Q.8, ties away from zero, then clamp to 32 bits.
  always_comb begin
    amag = acc_q[bfc_pkg::AccW-1] ? 64'(-acc_q) : 64'(acc_q);
    rr   = 49'(amag >> 16) + 49'(amag[15]);
    if (!acc_q[bfc_pkg::AccW-1]) begin
      sat = (rr > 49'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(rr[31:0]);
    end else begin
      sat = (rr > 49'h8000_0000) ? 32'sh8000_0000 : -$signed(rr[31:0]);
    end
  end

  assign out_free = !out_valid_q || out_ready_i;
  assign fe_pop_o = (state_q == ST_IDLE) && fe_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      lt_neg_q    <= 1'b0;
      lt_mag_q    <= '0;
      cnt_q       <= '0;
      step_q      <= '0;
    end else begin
      // a word loaded in the final state replaces the one leaving
      if (out_valid_q && out_ready_i && state_q != ST_FINAL) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (fe_valid_i) begin
            state_q <= ST_DIV;
            cnt_q   <= 5'(bfc_pkg::QW - 1);
          end
        end
        ST_DIV: begin
          cnt_q <= cnt_q - 5'd1;
          if (cnt_q == 5'd0) begin
            step_q  <= 3'd0;
            state_q <= isp_q ? ST_MLO : ST_TEMP;
          end
        end
        ST_TEMP: begin
          lt_neg_q <= neg_q;
          lt_mag_q <= q_q;
          state_q  <= ST_FINAL;
        end
        ST_MLO:  state_q <= ST_MHI;
        ST_MHI:  state_q <= ST_MACC;
        ST_MACC: begin
          step_q  <= step_q + 3'd1;
          state_q <= (step_q == 3'd5) ? ST_FINAL : ST_MLO;
        end
        ST_FINAL: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (fe_valid_i) begin
          isp_q <= fe_item_i.is_p;
          neg_q <= fe_item_i.neg;
          k_q   <= kval;
          rem_q <= bfc_pkg::KW'(num[NumW-1:bfc_pkg::QW]);
          nlo_q <= num[bfc_pkg::QW-1:0];
        end
      end
      ST_DIV: begin
        rem_q <= ge ? diff[bfc_pkg::KW-1:0] : trial[bfc_pkg::KW-1:0];
        nlo_q <= {nlo_q[bfc_pkg::QW-2:0], 1'b0};
        q_q   <= {q_q[bfc_pkg::QW-2:0], ge};
      end
      ST_TEMP: acc_q <= temp_acc;
      ST_MLO: begin
        amag_q <= asel;
        sgn_q  <= aneg ^ bsel[bfc_pkg::AccW-1];
        bhi_q  <= bmag[bfc_pkg::BMagW-1:bfc_pkg::BHalfW];
        plo_q  <= asel * bmag[bfc_pkg::BHalfW-1:0];
      end
      ST_MHI: phi_q <= amag_q * bhi_q;
      ST_MACC: begin
        acc_q <= acc_step;
        if (step_q == 3'd2) begin
          hsave_q <= acc_step;
        end
      end
      ST_FINAL: begin
        if (out_free) begin
          value_q   <= sat;
          isp_out_q <= isp_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign value_o       = value_q;
  assign is_pressure_o = isp_out_q;

endmodule

`default_nettype wire

[rtl/barometer_fifo_compensation.sv]
// ----------------------------------------------------------------------------
// barometer_fifo_compensation
// Compensates barometer FIFO words into temperature or pressure, Q24.8.
//
//   channel  dir  signals                                   accept
//   in       in   in_valid_i/in_ready_o, fifo_word_i        valid & ready
//   out      out  out_valid_o/out_ready_i, value_o,         valid & ready
//                 is_pressure_o
//   cfg      in   cfg_valid_i/cfg_ready_o, cfg_index_i,     valid & ready
//                 cfg_data_i
//
// A word passes through the back end in order: a pop from the queue, the
// one-bit-per-cycle divider, then either one multiply-add for temperature or
// six passes of the shared split multiplier for pressure, and a load of the
// output register; a stalled output holds it there. Two words queue in front,
// so input is taken while the back end is busy. Reset clears control state,
// coefficients, queue and the stored temperature; cfg is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module barometer_fifo_compensation (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [23:0]                fifo_word_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic signed [31:0]              value_o,
  output logic                            is_pressure_o,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [2:0]                 cfg_index_i,
  input  wire logic [31:0]                cfg_data_i
);

  bfc_pkg::cfg_t  cfg_q;
  bfc_pkg::item_t fe_item;
  logic           fe_valid, fe_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (bfc_pkg::reg_idx_e'(cfg_index_i))
        bfc_pkg::REG_TEMP_COEFFS: begin
          cfg_q.c0 <= cfg_data_i[23:12];
          cfg_q.c1 <= cfg_data_i[11:0];
        end
        bfc_pkg::REG_PRES_OFFSET:  cfg_q.c00 <= cfg_data_i[19:0];
        bfc_pkg::REG_PRES_LINEAR:  cfg_q.c10 <= cfg_data_i[19:0];
        bfc_pkg::REG_TEMP_LINEAR:  cfg_q.c01 <= cfg_data_i[15:0];
        bfc_pkg::REG_CROSS_LINEAR: cfg_q.c11 <= cfg_data_i[15:0];
        bfc_pkg::REG_PRES_SQUARE:  cfg_q.c20 <= cfg_data_i[15:0];
        bfc_pkg::REG_HIGH_ORDER: begin
          cfg_q.c21 <= cfg_data_i[31:16];
          cfg_q.c30 <= cfg_data_i[15:0];
        end
        bfc_pkg::REG_OVERSAMPLE: begin
          cfg_q.p_osr <= cfg_data_i[2:0];
          cfg_q.t_osr <= cfg_data_i[5:3];
        end
        default: ;
      endcase
    end
  end

  bfc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .fifo_word_i (fifo_word_i),
    .fe_valid_o  (fe_valid),
    .fe_item_o   (fe_item),
    .fe_pop_i    (fe_pop)
  );

  bfc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .fe_valid_i    (fe_valid),
    .fe_item_i     (fe_item),
    .fe_pop_o      (fe_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .value_o       (value_o),
    .is_pressure_o (is_pressure_o)
  );

`ifndef SYNTHESIS
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fe_pop |-> fe_valid) else $error("back end popped an empty queue");

  a_full_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> fe_valid) else $error("queue full but nothing to pop");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fe_pop |=> !fe_pop) else $error("back end took two words back to back");
`endif

endmodule

`default_nettype wire

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for barometer_fifo_compensation: directed and random
// FIFO words under several coefficient settings, checked against an in-bench
// fixed-point model of the compensation, with random idling on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint MaxS64   = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam int     CycLimit = 1000000;
  localparam int     TailWait = 120;

  typedef struct {
    logic signed [31:0] value;
    logic               is_p;
  } comp_result_t;

  // Fixed-point compensation model plus the queue of pending results.
  class comp_scoreboard;
    logic [31:0]  regs [8];
    longint       temp_scaled;
    comp_result_t pending [$];

    function new();
      foreach (regs[i]) regs[i] = '0;
      temp_scaled = 0;
    endfunction

    function void write_reg(bfc_pkg::reg_idx_e idx, logic [31:0] data);
      case (idx)
        bfc_pkg::REG_TEMP_COEFFS:  regs[idx] = data & 32'hFF_FFFF;
        bfc_pkg::REG_PRES_OFFSET,
        bfc_pkg::REG_PRES_LINEAR:  regs[idx] = data & 32'hF_FFFF;
        bfc_pkg::REG_TEMP_LINEAR,
        bfc_pkg::REG_CROSS_LINEAR,
        bfc_pkg::REG_PRES_SQUARE:  regs[idx] = data & 32'hFFFF;
        bfc_pkg::REG_HIGH_ORDER:   regs[idx] = data;
        default:                   regs[idx] = data & 32'h3F;
      endcase
    endfunction

    function logic [63:0] mag(longint v);
      return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function longint signed_of(logic [63:0] m, bit neg);
      if (m > 64'(MaxS64)) m = 64'(MaxS64);
      return neg ? -longint'(m) : longint'(m);
    endfunction

    // round(a*b / 2^24), ties away from zero
    function longint mul_q24(longint a, longint b);
      logic [127:0] p;
      logic [63:0]  q;
      p = {64'd0, mag(a)} * {64'd0, mag(b)} + 128'd8388608;
      q = (p[127:88] != 0) ? 64'(MaxS64) : p[87:24];
      return signed_of(q, (a < 0) != (b < 0));
    endfunction

    function longint scale_raw(longint raw, logic [2:0] code);
      logic [63:0] k, m;
      case (code)
        3'd0: k = 524288;
        3'd1: k = 1572864;
        3'd2: k = 3670016;
        3'd3: k = 7864320;
        3'd4: k = 253952;
        3'd5: k = 516096;
        3'd6: k = 1040384;
        default: k = 2088960;
      endcase
      m = ((mag(raw) << 24) + k / 2) / k;
      return signed_of(m, raw < 0);
    endfunction

    function logic signed [31:0] q8_saturate(longint v);
      logic [63:0] m;
      longint      r;
      m = mag(v);
      m = (m >> 16) + ((m >> 15) & 64'd1);
      r = signed_of(m, v < 0);
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      return r[31:0];
    endfunction

    function comp_result_t compensate(logic [23:0] word);
      comp_result_t res;
      longint raw, x, h, g, c0, c1;
      raw = longint'(signed'(word));
      res.is_p = word[0];
      if (!word[0]) begin
        c0 = longint'(signed'(regs[bfc_pkg::REG_TEMP_COEFFS][23:12]));
        c1 = longint'(signed'(regs[bfc_pkg::REG_TEMP_COEFFS][11:0]));
        x = scale_raw(raw, regs[bfc_pkg::REG_OVERSAMPLE][5:3]);
        temp_scaled = x;
        res.value = q8_saturate(c0 * 64'sd8388608 + c1 * x);
      end else begin
        x = scale_raw(raw, regs[bfc_pkg::REG_OVERSAMPLE][2:0]);
        h = longint'(signed'(regs[bfc_pkg::REG_HIGH_ORDER][15:0])) <<< 24;
        h = (longint'(signed'(regs[bfc_pkg::REG_PRES_SQUARE][15:0])) <<< 24)
          + mul_q24(x, h);
        h = (longint'(signed'(regs[bfc_pkg::REG_PRES_LINEAR][19:0])) <<< 24)
          + mul_q24(x, h);
        h = (longint'(signed'(regs[bfc_pkg::REG_PRES_OFFSET][19:0])) <<< 24)
          + mul_q24(x, h);
        g = longint'(signed'(regs[bfc_pkg::REG_HIGH_ORDER][31:16])) <<< 24;
        g = (longint'(signed'(regs[bfc_pkg::REG_CROSS_LINEAR][15:0])) <<< 24)
          + mul_q24(x, g);
        g = (longint'(signed'(regs[bfc_pkg::REG_TEMP_LINEAR][15:0])) <<< 24)
          + mul_q24(x, g);
        res.value = q8_saturate(h + mul_q24(temp_scaled, g));
      end
      return res;
    endfunction

    function void note_word(logic [23:0] word);
      pending.push_back(compensate(word));
    endfunction

    // Returns an empty string when the word matches.
    function string check_result(logic signed [31:0] value, logic is_p);
      comp_result_t exp_res;
      if (pending.size() == 0)
        return $sformatf("unexpected result value=%0d is_p=%0b", value, is_p);
      exp_res = pending.pop_front();
      if (value !== exp_res.value || is_p !== exp_res.is_p)
        return $sformatf("got value=%0d is_p=%0b, want value=%0d is_p=%0b",
                         value, is_p, exp_res.value, exp_res.is_p);
      return "";
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [23:0]       fifo_word_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic signed [31:0] value_o;
  logic              is_pressure_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [2:0]        cfg_index_i = '0;
  logic [31:0]       cfg_data_i = '0;

  comp_scoreboard sb = new();
  int fails = 0;
  int cycles = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  barometer_fifo_compensation u_dut (.*);

  always #6 clk_i = ~clk_i;

  task automatic report(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    fails++;
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side: check each accepted word, then pick ready for the next edge.
  always @(posedge clk_i) begin
    string msg;
    if (rst_ni && out_valid_o && out_ready_i) begin
      msg = sb.check_result(value_o, is_pressure_o);
      if (msg != "") report(msg);
    end
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_word(logic [23:0] word);
    in_valid_i  <= 1'b1;
    fifo_word_i <= word;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_word(word);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (TailWait) @(posedge clk_i);
  endtask

  // Leaves valid high; the caller drops it after the last write.
  task automatic write_reg(bfc_pkg::reg_idx_e idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
  endtask

  function automatic logic [15:0] small16();
    return 16'($signed($urandom_range(0, 511)) - 256);
  endfunction

  // style: 0 max, 1 min, 2 full random, 3 small realistic
  function automatic logic [31:0] reg_value(bfc_pkg::reg_idx_e idx, int style);
    logic [31:0] r;
    logic [15:0] s0, s1;
    r  = $urandom();
    s0 = small16();
    s1 = small16();
    case (style)
      0: case (idx)
        bfc_pkg::REG_TEMP_COEFFS:  return 32'h7FF7FF;
        bfc_pkg::REG_PRES_OFFSET,
        bfc_pkg::REG_PRES_LINEAR:  return 32'h7FFFF;
        bfc_pkg::REG_HIGH_ORDER:   return 32'h7FFF7FFF;
        bfc_pkg::REG_OVERSAMPLE:   return 32'h3F;
        default:                   return 32'h7FFF;
      endcase
      1: case (idx)
        bfc_pkg::REG_TEMP_COEFFS:  return 32'h800800;
        bfc_pkg::REG_PRES_OFFSET,
        bfc_pkg::REG_PRES_LINEAR:  return 32'h80000;
        bfc_pkg::REG_HIGH_ORDER:   return 32'h80008000;
        bfc_pkg::REG_OVERSAMPLE:   return 32'h0;
        default:                   return 32'h8000;
      endcase
      2: return r;
      default: case (idx)
        bfc_pkg::REG_TEMP_COEFFS:  return {r[31:24], s0[11:0], s1[11:0]};
        bfc_pkg::REG_PRES_OFFSET,
        bfc_pkg::REG_PRES_LINEAR:  return r;
        bfc_pkg::REG_HIGH_ORDER:   return {s0 >>> 4, s1 >>> 6};
        bfc_pkg::REG_OVERSAMPLE:   return r;
        default:                   return {r[31:16], s0};
      endcase
    endcase
  endfunction

  function automatic logic [23:0] rand_word();
    logic [23:0] w;
    w = 24'($urandom());
    case ($urandom_range(5))
      0: w = {w[23], {23{w[23]}}} ^ {16'h0, w[7:0]};
      1: w = {w[0] ? 24'h7FFFFF : 24'h800000} ^ 24'(w[0]);
      default: ;
    endcase
    return w;
  endfunction

  initial begin
    logic [23:0] directed [12] = '{24'h000001, 24'h000000, 24'h7FFFFF, 24'h7FFFFE,
                                   24'h800000, 24'h800001, 24'hFFFFFF, 24'hFFFFFE,
                                   24'h000003, 24'h555555, 24'hAAAAAA, 24'h000002};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // pressure before any temperature uses the reset temperature
    send_word(24'h123457);
    drain();
    for (int phase = 0; phase < 9; phase++) begin
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 75; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 75; end
        default: begin idle_pct = 11; stall_pct = 11; end
      endcase
      for (int i = 0; i < 8; i++)
        write_reg(bfc_pkg::reg_idx_e'(i),
                  reg_value(bfc_pkg::reg_idx_e'(i),
                            phase < 3 ? 3 - phase : 2 + phase % 2));
      cfg_valid_i <= 1'b0;
      if (phase < 3) begin
        foreach (directed[i]) send_word(directed[i]);
      end else begin
        // lead with pressure so the kept temperature spans a rate change
        send_word(rand_word() | 24'h1);
        for (int i = 0; i < 120; i++) begin
          if (i == 60) drain();
          send_word(rand_word());
        end
      end
      drain();
    end
    if (fails == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire

[barometer_fifo_compensation.f]
rtl/bfc_pkg.sv
rtl/bfc_front.sv
rtl/bfc_back.sv
rtl/barometer_fifo_compensation.sv
tb/tb.sv
